[hdl/frs_pkg.sv]
// shared types, constants and the segment decoder for the frame-rate display unit
`default_nettype none

package frs_pkg;

   // dividend of the rate division: hundredths of a frame per second
   localparam int unsigned QUOT_BITS  = 27;
   localparam logic [QUOT_BITS-1:0] RATE_SCALE = 27'd100000000;

   // four decimal digits kept on the display
   localparam int unsigned DIGIT_COUNT = 4;
   localparam int unsigned BCD_BITS    = 4 * DIGIT_COUNT;

   // shown when the elapsed time is zero
   localparam logic [BCD_BITS-1:0] DIGITS_SATURATED = 16'h9999;

   // decimal point segment
   localparam logic [7:0] SEG_POINT = 8'h80;

   // common-cathode patterns, bit0 is segment a
   localparam logic [7:0] SEG_ZERO  = 8'h3F;
   localparam logic [7:0] SEG_ONE   = 8'h06;
   localparam logic [7:0] SEG_TWO   = 8'h5B;
   localparam logic [7:0] SEG_THREE = 8'h4F;
   localparam logic [7:0] SEG_FOUR  = 8'h66;
   localparam logic [7:0] SEG_FIVE  = 8'h6D;
   localparam logic [7:0] SEG_SIX   = 8'h7D;
   localparam logic [7:0] SEG_SEVEN = 8'h07;
   localparam logic [7:0] SEG_EIGHT = 8'h7F;
   localparam logic [7:0] SEG_NINE  = 8'h6F;
   localparam logic [7:0] SEG_BLANK = 8'h00;

   // input item
   typedef struct packed {
      logic [31:0] start_count;
      logic [31:0] end_count;
   } req_type;

   // result item
   typedef struct packed {
      logic [7:0]  tens_segments;
      logic [23:0] low_segments;
      logic        zero_time;
   } rsp_type;

   // one divider / bcd pipeline stage
   typedef struct packed {
      logic                valid;
      logic                zero;
      logic [31:0]         divisor;
      logic [31:0]         rem;
      logic [BCD_BITS-1:0] bcd;
   } stage_type;

   // bcd digit to segment pattern
   function automatic logic [7:0] seg_encode(input logic [3:0] digit);
      logic [7:0] seg;
      unique case (digit)
         4'd0:    seg = SEG_ZERO;
         4'd1:    seg = SEG_ONE;
         4'd2:    seg = SEG_TWO;
         4'd3:    seg = SEG_THREE;
         4'd4:    seg = SEG_FOUR;
         4'd5:    seg = SEG_FIVE;
         4'd6:    seg = SEG_SIX;
         4'd7:    seg = SEG_SEVEN;
         4'd8:    seg = SEG_EIGHT;
         4'd9:    seg = SEG_NINE;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

[hdl/frs_div_step.sv]
// one restoring-division step with one double-dabble step on the quotient bits so far
`default_nettype none

module frs_div_step
   import frs_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      enable,
   input  wire logic      num_bit,
   input  wire stage_type stage_i,
   output stage_type      stage_o
);

   logic [32:0]         partial;
   logic [32:0]         diff;
   logic                qbit;
   logic [BCD_BITS-1:0] adj;
   stage_type           stage_in;
   stage_type           stage_ff;

   // bring down the next dividend bit and try the subtraction
   always_comb begin
      partial = {stage_i.rem, num_bit};
      diff    = partial - {1'b0, stage_i.divisor};
      qbit    = (partial >= {1'b0, stage_i.divisor});
   end

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int j = 0; j < DIGIT_COUNT; j++) begin
         if (stage_i.bcd[4*j +: 4] >= 4'd5) begin
            adj[4*j +: 4] = stage_i.bcd[4*j +: 4] + 4'd3;
         end else begin
            adj[4*j +: 4] = stage_i.bcd[4*j +: 4];
         end
      end
   end

   // next stage contents, top digit carry dropped
   always_comb begin
      stage_in         = stage_i;
      stage_in.rem     = qbit ? diff[31:0] : partial[31:0];
      stage_in.bcd     = {adj[BCD_BITS-2:0], qbit};
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

`default_nettype wire

[hdl/frs_div_pipe.sv]
// chain of division steps, one quotient bit per stage, most significant first
`default_nettype none

module frs_div_pipe
   import frs_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      enable,
   input  wire stage_type stage_i,
   output stage_type      stage_o
);

   stage_type pipe_w [0:QUOT_BITS];

   assign pipe_w[0] = stage_i;

   // one stage for each dividend bit
   for (genvar i = 0; i < QUOT_BITS; i++) begin : g_step
      frs_div_step u_step (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .num_bit (RATE_SCALE[QUOT_BITS-1-i]),
         .stage_i (pipe_w[i]),
         .stage_o (pipe_w[i+1])
      );
   end

   assign stage_o = pipe_w[QUOT_BITS];

endmodule

`default_nettype wire

[hdl/frs_seg_out.sv]
// segment encoding, output register and skid register
`default_nettype none

module frs_seg_out
   import frs_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire stage_type stage_i,
   output logic           enable,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output rsp_type        rsp_payload
);

   logic [BCD_BITS-1:0] digits;
   rsp_type             enc;
   logic                incoming;
   logic                take;
   rsp_type             out_ff;
   logic                out_valid_ff;
   rsp_type             skid_ff;
   logic                skid_valid_ff;

   // saturate on zero elapsed time, then decode each digit
   always_comb begin
      digits            = stage_i.zero ? DIGITS_SATURATED : stage_i.bcd;
      enc.tens_segments = seg_encode(digits[15:12]);
      enc.low_segments  = {seg_encode(digits[11:8]) | SEG_POINT,
                           seg_encode(digits[7:4]),
                           seg_encode(digits[3:0])};
      enc.zero_time     = stage_i.zero;
   end

   // pipeline moves whenever the skid register is free
   assign enable   = !skid_valid_ff;
   assign incoming = stage_i.valid && enable;
   assign take     = out_valid_ff && !rsp_stall;

   // output and skid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take || !out_valid_ff) begin
            out_ff        <= skid_ff;
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (incoming) begin
         if (take || !out_valid_ff) begin
            out_ff       <= enc;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= enc;
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

`default_nettype wire

[hdl/frame_rate_seven_segment_unit.sv]
// top level of the frame-rate seven-segment display unit
//
//  channel | ports                               | direction | item
//  --------+-------------------------------------+-----------+---------------------------------
//  req     | req_valid, req_stall, req_payload   | in        | start and end counter readings
//  rsp     | rsp_valid, rsp_stall, rsp_payload   | out       | four digit patterns, zero flag
//
// one item per cycle is accepted while req_stall is low; each result passes through
// the subtract stage, 27 restoring-division stages (one quotient bit each)
// and the output register.
// reset is synchronous and clears all valid bits; payload registers are not reset.
// a stall on rsp fills the skid register, which then holds the whole pipeline and
// raises req_stall; nothing in flight is lost or repeated.
`default_nettype none

module frame_rate_seven_segment_unit
   import frs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   logic        enable;
   logic        accept;
   logic [31:0] elapsed;
   stage_type   head_in;
   stage_type   head_ff;
   stage_type   tail_w;

   assign req_stall = !enable;
   assign accept    = req_valid && !req_stall;

   // elapsed time modulo 2^32
   always_comb begin
      elapsed         = req_payload.end_count - req_payload.start_count;
      head_in.valid   = accept;
      head_in.zero    = (elapsed == 32'd0);
      head_in.divisor = elapsed;
      head_in.rem     = 32'd0;
      head_in.bcd     = '0;
   end

   // subtract stage
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (enable) begin
         head_ff <= head_in;
      end
   end

   frs_div_pipe u_div_pipe (
      .clock   (clock),
      .reset   (reset),
      .enable  (enable),
      .stage_i (head_ff),
      .stage_o (tail_w)
   );

   frs_seg_out u_seg_out (
      .clock       (clock),
      .reset       (reset),
      .stage_i     (tail_w),
      .enable      (enable),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // input is held back only while a result is waiting at the output
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with an empty output register");

   // skid register fills only behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("skid register filled without output stall");

   // zero elapsed time shows 99.99
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.zero_time) |->
         (rsp_payload.tens_segments == SEG_NINE &&
          rsp_payload.low_segments == {SEG_NINE | SEG_POINT, SEG_NINE, SEG_NINE}))
      else $error("zero elapsed time not saturated to 99.99");

endmodule

`default_nettype wire

[test/tb.sv]
// self-checking testbench for the frame-rate seven-segment display unit
`default_nettype none

module tb;
   import frs_pkg::*;

   // rate dividend, stimulus sizes, stall plan and the idle limit of the watchdog
   localparam int unsigned RATE_HUNDREDTHS = 100_000_000;
   localparam int unsigned RANDOM_FRAMES   = 1400;
   localparam int unsigned IDLE_LIMIT      = 3000;
   localparam int unsigned DRAIN_CYCLES    = 40;
   localparam int unsigned HOLD_CYCLES     = 400;
   localparam int unsigned HOLD_AT_RESULT  = 300;
   localparam int unsigned QUIET_FIRST     = 700;
   localparam int unsigned QUIET_LAST      = 900;
   localparam int unsigned IDLE_PERCENT    = 32;

   // glyphs indexed by decimal digit
   localparam logic [9:0][7:0] DIGIT_GLYPH = {
      SEG_NINE, SEG_EIGHT, SEG_SEVEN, SEG_SIX, SEG_FIVE,
      SEG_FOUR, SEG_THREE, SEG_TWO, SEG_ONE, SEG_ZERO
   };

   // one planned frame reading, with a hand-typed result where one is known
   typedef struct {
      req_type frame;
      bit      known;
      rsp_type want;
   } frame_plan_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   frame_plan_type frame_q[$];
   rsp_type        display_expect_q[$];

   bit          feeding       = 1'b0;
   int unsigned frames_sent   = 0;
   int unsigned directed_rows = 0;
   int unsigned results_seen  = 0;
   int unsigned mismatch_count = 0;
   int unsigned zero_frames   = 0;
   int unsigned wrapped_frames = 0;
   int unsigned fast_frames   = 0;
   int unsigned idle_cycles   = 0;

   frame_rate_seven_segment_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   // expected display for one pair of counter readings
   function automatic rsp_type rate_to_display(input req_type frame);
      int unsigned elapsed;
      int unsigned shown;
      rsp_type     disp;
      elapsed = frame.end_count - frame.start_count;
      if (elapsed == 0) begin
         shown = 9999;
      end else begin
         shown = (RATE_HUNDREDTHS / elapsed) % 10000;
      end
      disp.tens_segments = DIGIT_GLYPH[4'((shown / 1000) % 10)];
      disp.low_segments  = {DIGIT_GLYPH[4'((shown / 100) % 10)] | SEG_POINT,
                            DIGIT_GLYPH[4'((shown / 10) % 10)],
                            DIGIT_GLYPH[4'(shown % 10)]};
      disp.zero_time     = (elapsed == 0);
      return disp;
   endfunction

   // append one reading to the stimulus plan
   task automatic plan_frame(input logic [31:0] t0, input logic [31:0] t1,
                             input bit known, input rsp_type want);
      frame_plan_type row;
      row.frame.start_count = t0;
      row.frame.end_count   = t1;
      row.known             = known;
      row.want              = want;
      frame_q.push_back(row);
   endtask

   // elapsed time spread over the interesting ranges
   function automatic logic [31:0] pick_elapsed();
      logic [31:0] span;
      case ($urandom_range(19))
         0:          span = 32'd0;
         1, 2, 3:    span = $urandom_range(20000, 1);
         16, 17:     span = $urandom;
         18:         span = RATE_HUNDREDTHS - 32'd50 + $urandom_range(100);
         19:         span = $urandom_range(100, 1);
         13, 14, 15: span = $urandom_range(100_000_000, 1_000_000);
         default:    span = $urandom_range(10_000_000, 10_000);
      endcase
      return span;
   endfunction

   // result check against the oldest expectation
   task automatic check_display(input rsp_type got);
      rsp_type want;
      results_seen++;
      if (display_expect_q.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("error: result with nothing expected: tens %h low %h zero %b",
                     got.tens_segments, got.low_segments, got.zero_time);
      end else begin
         want = display_expect_q.pop_front();
         if (got.tens_segments !== want.tens_segments ||
             got.low_segments  !== want.low_segments  ||
             got.zero_time     !== want.zero_time) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("error: result %0d: tens %h/%h low %h/%h zero %b/%b (exp/act)",
                        results_seen, want.tens_segments, got.tens_segments,
                        want.low_segments, got.low_segments,
                        want.zero_time, got.zero_time);
         end
      end
   endtask

   // sender: offers planned items, holding a stalled one unchanged
   always @(posedge clock) begin : feed
      bit          taken;
      bit          offer;
      bit          quiet;
      int unsigned elapsed;
      taken = req_valid && !req_stall;
      if (taken) begin
         if (frame_q[frames_sent].known)
            display_expect_q.push_back(frame_q[frames_sent].want);
         else
            display_expect_q.push_back(rate_to_display(frame_q[frames_sent].frame));
         elapsed = req_payload.end_count - req_payload.start_count;
         if (elapsed == 0)
            zero_frames++;
         else if (elapsed <= RATE_HUNDREDTHS / 10000)
            fast_frames++;
         if (req_payload.end_count < req_payload.start_count)
            wrapped_frames++;
         frames_sent++;
      end
      if (!req_valid || taken) begin
         quiet = frames_sent >= QUIET_FIRST && frames_sent < QUIET_LAST;
         offer = feeding && frames_sent < frame_q.size() &&
                 (quiet || $urandom_range(99) >= IDLE_PERCENT);
         req_valid <= offer;
         if (offer)
            req_payload <= frame_q[frames_sent].frame;
      end
   end

   // receiver: random stalls, one long hold-off, one quiet stretch
   always @(posedge clock) begin : drain
      static int unsigned hold_left = 0;
      static bit          hold_done = 1'b0;
      if (!reset && rsp_valid && !rsp_stall)
         check_display(rsp_payload);
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (results_seen >= QUIET_FIRST && results_seen < QUIET_LAST) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: %0d cycles with no item accepted", idle_cycles);
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // plan, reset, run and report
   initial begin : run
      logic [31:0] t0;
      // saturated display, counter extremes and wrap
      plan_frame(32'h0000_0000, 32'h0000_0000, 1'b1,
                 '{SEG_NINE, {SEG_NINE | SEG_POINT, SEG_NINE, SEG_NINE}, 1'b1});
      plan_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                 '{SEG_NINE, {SEG_NINE | SEG_POINT, SEG_NINE, SEG_NINE}, 1'b1});
      plan_frame(32'h0000_0000, 32'h0000_0001, 1'b1,
                 '{SEG_ZERO, {SEG_ZERO | SEG_POINT, SEG_ZERO, SEG_ZERO}, 1'b0});
      plan_frame(32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
                 '{SEG_ZERO, {SEG_ZERO | SEG_POINT, SEG_ZERO, SEG_ZERO}, 1'b0});
      plan_frame(32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
                 '{SEG_ZERO, {SEG_ZERO | SEG_POINT, SEG_ZERO, SEG_ZERO}, 1'b0});
      plan_frame(32'h0000_0005, 32'h0000_0004, 1'b1,
                 '{SEG_ZERO, {SEG_ZERO | SEG_POINT, SEG_ZERO, SEG_ZERO}, 1'b0});
      // the lowest nonzero display, 00.01, and its neighbours
      plan_frame(32'h0000_0000, 32'd100_000_000, 1'b1,
                 '{SEG_ZERO, {SEG_ZERO | SEG_POINT, SEG_ZERO, SEG_ONE}, 1'b0});
      plan_frame(32'h0000_0000, 32'd99_999_999, 1'b1,
                 '{SEG_ZERO, {SEG_ZERO | SEG_POINT, SEG_ZERO, SEG_ONE}, 1'b0});
      plan_frame(32'h0000_0000, 32'd100_000_001, 1'b1,
                 '{SEG_ZERO, {SEG_ZERO | SEG_POINT, SEG_ZERO, SEG_ZERO}, 1'b0});
      // 1, 10 and 100 fps, the last one wrapping to zero
      plan_frame(32'h1000_0000, 32'h1000_0000 + 32'd1_000_000, 1'b1,
                 '{SEG_ZERO, {SEG_ONE | SEG_POINT, SEG_ZERO, SEG_ZERO}, 1'b0});
      plan_frame(32'h2000_0000, 32'h2000_0000 + 32'd100_000, 1'b1,
                 '{SEG_ONE, {SEG_ZERO | SEG_POINT, SEG_ZERO, SEG_ZERO}, 1'b0});
      plan_frame(32'h3000_0000, 32'h3000_0000 + 32'd10_000, 1'b1,
                 '{SEG_ZERO, {SEG_ZERO | SEG_POINT, SEG_ZERO, SEG_ZERO}, 1'b0});
      // high rates that wrap, mid rates, wrap across the counter top
      plan_frame(32'h0000_0000, 32'd8_100, 1'b0, '0);
      plan_frame(32'hFFFF_F000, 32'h0000_2000, 1'b0, '0);
      plan_frame(32'h0000_0000, 32'd12_345, 1'b0, '0);
      plan_frame(32'h0000_0000, 32'd33_333, 1'b0, '0);
      plan_frame(32'h0000_0000, 32'd1_234_567, 1'b0, '0);
      plan_frame(32'hFFFF_0000, 32'h0001_0000, 1'b0, '0);
      // alternating bit patterns, then the top bit alone against all the others
      plan_frame(32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0);
      plan_frame(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0);
      plan_frame(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0);
      directed_rows = frame_q.size();

      // random readings: random start, elapsed spread over the ranges or now and then a random end
      for (int n = 0; n < RANDOM_FRAMES; n++) begin
         t0 = $urandom;
         if ($urandom_range(19) == 0)
            plan_frame(t0, $urandom, 1'b0, '0);
         else
            plan_frame(t0, t0 + pick_elapsed(), 1'b0, '0);
      end

      repeat (6) @(posedge clock);
      reset   <= 1'b0;
      feeding <= 1'b1;

      while (frames_sent < frame_q.size()) @(posedge clock);
      while (display_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d directed and %0d random readings, %0d results checked",
               directed_rows, frame_q.size() - directed_rows, results_seen);
      $display("zero elapsed %0d, counter wrapped %0d, rates of 100 fps or more %0d",
               zero_frames, wrapped_frames, fast_frames);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
